// File: sv/prmp_pkg.sv
// prmp_pkg: shared types and constants for the permutation rank unit
// no dependencies; imported by every module of the block except prmp_cell

package prmp_pkg;

    localparam int unsigned RankW = 30;

    // modulus of the rank and factorial arithmetic
    localparam logic [RankW-1:0] RankMod = 30'd1000000007;

    // barrett reciprocal floor(2^60 / RankMod), fits in 31 bits
    localparam logic [30:0] BarrettM = 31'((64'd1 << 60) / 64'(RankMod));

    localparam int unsigned InValueW = 32;

    typedef struct packed {
        logic signed [InValueW-1:0] value;
        logic                       last;
    } in_item_t;

    typedef struct packed {
        logic [RankW-1:0] rank;
        logic             done_res;
        logic             overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        StIdle,
        StCmp,
        StCount,
        StMul,
        StFin
    } seq_state_t;

    typedef enum logic {
        TagFact,
        TagRank
    } mul_tag_t;

    typedef struct packed {
        logic     valid;
        mul_tag_t tag;
    } mul_req_t;

    typedef struct packed {
        logic             valid;
        mul_tag_t         tag;
        logic [RankW-1:0] result;
    } mul_rsp_t;

    typedef struct packed {
        logic valid;
        logic any_eq;
    } count_res_t;

endpackage

// File: sv/prmp_cell.sv
// prmp_cell: one store cell of the value chain, holds a biased key and an occupancy bit
// compares the held key with the broadcast key; depends on nothing but its ports

module prmp_cell #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  shift_en,
    input  logic                  clear,
    input  logic [VALUE_BITS-1:0] prev_value,
    input  logic                  prev_valid,
    input  logic [VALUE_BITS-1:0] key,
    output logic [VALUE_BITS-1:0] value_o,
    output logic                  valid_o,
    output logic                  lt,
    output logic                  eq
);

    logic [VALUE_BITS-1:0] value_reg;
    logic                  valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            value_reg <= prev_value;
        end
    end

    assign value_o = value_reg;
    assign valid_o = valid_reg;
    assign lt      = valid_reg && (value_reg < key);
    assign eq      = valid_reg && (value_reg == key);

endmodule

// File: sv/prmp_count_tree.sv
// prmp_count_tree: registered binary tree that counts the less-than flags of the cells
// and ors their equal flags, with one register stage per tree level; uses prmp_pkg

module prmp_count_tree #(
    parameter int unsigned N = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  logic [N-1:0]               lt_bits,
    input  logic [N-1:0]               eq_bits,
    output logic [$clog2(N+1)-1:0]     cnt_o,
    output prmp_pkg::count_res_t       res_o
);

    import prmp_pkg::*;

    localparam int unsigned Levels = $clog2(N);
    localparam int unsigned Leaves = 1 << Levels;
    localparam int unsigned CntW   = $clog2(N + 1);

    logic [CntW-1:0] leaf_cnt [Leaves];
    logic            leaf_any [Leaves];
    logic [CntW-1:0] cnt_reg  [1:Leaves-1];
    logic            any_reg  [1:Leaves-1];
    logic [Levels-1:0] vld_reg;
    logic [Levels-1:0] vld_next;

    for (genvar j = 0; j < Leaves; j++) begin : g_leaf
        if (j < N) begin : g_used
            assign leaf_cnt[j] = {{(CntW-1){1'b0}}, lt_bits[j]};
            assign leaf_any[j] = eq_bits[j];
        end else begin : g_pad
            assign leaf_cnt[j] = '0;
            assign leaf_any[j] = 1'b0;
        end
    end

    // heap layout: node i adds nodes 2i and 2i+1, the bottom row reads the leaves
    for (genvar i = 1; i < Leaves; i++) begin : g_node
        if (2 * i >= Leaves) begin : g_bottom
            always_ff @(posedge aclk) begin
                cnt_reg[i] <= leaf_cnt[2*i-Leaves] + leaf_cnt[2*i+1-Leaves];
                any_reg[i] <= leaf_any[2*i-Leaves] | leaf_any[2*i+1-Leaves];
            end
        end else begin : g_inner
            always_ff @(posedge aclk) begin
                cnt_reg[i] <= cnt_reg[2*i] + cnt_reg[2*i+1];
                any_reg[i] <= any_reg[2*i] | any_reg[2*i+1];
            end
        end
    end

    assign vld_next = Levels'({vld_reg, in_valid});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign cnt_o        = cnt_reg[1];
    assign res_o.valid  = vld_reg[Levels-1];
    assign res_o.any_eq = any_reg[1];

endmodule

// File: sv/prmp_modmul.sv
// prmp_modmul: five-stage pipelined multiply modulo RankMod with barrett reduction
// operands must be below RankMod; uses prmp_pkg

module prmp_modmul (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  prmp_pkg::mul_req_t         req,
    input  logic [prmp_pkg::RankW-1:0] a,
    input  logic [prmp_pkg::RankW-1:0] b,
    output prmp_pkg::mul_rsp_t         rsp
);

    import prmp_pkg::*;

    localparam logic [31:0] ModW  = 32'(RankMod);
    localparam logic [31:0] Mod2W = ModW << 1;

    mul_req_t s1_req_reg, s2_req_reg, s3_req_reg, s4_req_reg, s5_req_reg;

    logic [59:0]      prod_reg;
    logic [61:0]      est_reg;
    logic [31:0]      low2_reg;
    logic [31:0]      low3_reg;
    logic [31:0]      qp_reg;
    logic [31:0]      rem_reg;
    logic [RankW-1:0] res_reg;

    logic [30:0]      quot;
    logic [RankW-1:0] res_next;

    assign quot = est_reg[61:31];

    // estimate is at most two below the true quotient, so the remainder is under 3 * RankMod
    always_comb begin
        if (rem_reg >= Mod2W) begin
            res_next = RankW'(rem_reg - Mod2W);
        end else if (rem_reg >= ModW) begin
            res_next = RankW'(rem_reg - ModW);
        end else begin
            res_next = RankW'(rem_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_req_reg <= '0;
            s2_req_reg <= '0;
            s3_req_reg <= '0;
            s4_req_reg <= '0;
            s5_req_reg <= '0;
        end else begin
            s1_req_reg <= req;
            s2_req_reg <= s1_req_reg;
            s3_req_reg <= s2_req_reg;
            s4_req_reg <= s3_req_reg;
            s5_req_reg <= s4_req_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 60'(a) * 60'(b);
        est_reg  <= 62'(prod_reg[59:29]) * 62'(BarrettM);
        low2_reg <= prod_reg[31:0];
        // remainder fits in 32 bits, so only the low word of q * RankMod is needed
        qp_reg   <= 32'(quot) * ModW;
        low3_reg <= low2_reg;
        rem_reg  <= low3_reg - qp_reg;
        res_reg  <= res_next;
    end

    assign rsp.valid  = s5_req_reg.valid;
    assign rsp.tag    = s5_req_reg.tag;
    assign rsp.result = res_reg;

endmodule

// File: sv/permutation_rank_mod_prime_unit.sv
// permutation_rank_mod_prime_unit: top level of the lexicographic rank modulo 1000000007
// uses prmp_pkg, prmp_cell, prmp_count_tree and prmp_modmul
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_data  (value, last)
//   m_      | out       | m_valid / m_ready  | m_data  (rank, done_res, overflow)
//
// one item at a time: the next transfer waits until the item has passed the count tree and
// the five-stage modular multiplier
// reset (aresetn low, synchronous) empties the cell chain and sets rank, factorial and
// position to one; the item flagged last does the same after its result
// a held result on m_ does not block the next input transfer; only the final step waits

module permutation_rank_mod_prime_unit #(
    parameter int unsigned MAX_LEN    = 256,
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  prmp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output prmp_pkg::out_item_t m_data
);

    import prmp_pkg::*;

    localparam int unsigned CntW = $clog2(MAX_LEN + 1);
    localparam logic [VALUE_BITS-1:0] SignMask = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [RankW-1:0] RankOne = 30'd1;
    localparam logic [RankW-1:0] ModLast = RankW'(RankMod - 30'd1);

    seq_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] key_reg, key_next;
    logic                  last_reg, last_next;
    logic                  ovf_reg, ovf_next;
    logic [RankW-1:0]      rank_reg, rank_next;
    logic [RankW-1:0]      fact_reg, fact_next;
    logic [RankW-1:0]      fact_new_reg, fact_new_next;
    logic [31:0]           pos_reg, pos_next;
    logic [RankW-1:0]      pos_mod_reg, pos_mod_next;
    logic [RankW:0]        sum_reg, sum_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    logic [63:0]           value_wide;
    logic [VALUE_BITS-1:0] key_in;
    logic [RankW-1:0]      rank_final;

    logic                  shift_en;
    logic                  cell_clear;
    logic                  tree_in_valid;
    logic [VALUE_BITS-1:0] cell_value [MAX_LEN];
    logic [MAX_LEN-1:0]    cell_valid;
    logic [MAX_LEN-1:0]    lt_bits;
    logic [MAX_LEN-1:0]    eq_bits;
    logic                  store_full;

    logic [CntW-1:0]       cnt;
    count_res_t            cnt_res;

    mul_req_t              mul_req;
    logic [RankW-1:0]      mul_a;
    logic [RankW-1:0]      mul_b;
    mul_rsp_t              mul_rsp;

    // sign-extend, keep VALUE_BITS bits, flip the sign so unsigned order is signed order
    assign value_wide = 64'(s_data.value);
    assign key_in     = value_wide[VALUE_BITS-1:0] ^ SignMask;

    // new values enter at cell 0 and push the chain along
    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        if (i == 0) begin : g_head
            prmp_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .shift_en   (shift_en),
                .clear      (cell_clear),
                .prev_value (key_reg),
                .prev_valid (1'b1),
                .key        (key_reg),
                .value_o    (cell_value[i]),
                .valid_o    (cell_valid[i]),
                .lt         (lt_bits[i]),
                .eq         (eq_bits[i])
            );
        end else begin : g_body
            prmp_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .shift_en   (shift_en),
                .clear      (cell_clear),
                .prev_value (cell_value[i-1]),
                .prev_valid (cell_valid[i-1]),
                .key        (key_reg),
                .value_o    (cell_value[i]),
                .valid_o    (cell_valid[i]),
                .lt         (lt_bits[i]),
                .eq         (eq_bits[i])
            );
        end
    end

    assign store_full = cell_valid[MAX_LEN-1];

    prmp_count_tree #(.N(MAX_LEN)) u_tree (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (tree_in_valid),
        .lt_bits  (lt_bits),
        .eq_bits  (eq_bits),
        .cnt_o    (cnt),
        .res_o    (cnt_res)
    );

    prmp_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .a       (mul_a),
        .b       (mul_b),
        .rsp     (mul_rsp)
    );

    assign rank_final = (sum_reg >= (RankW+1)'(RankMod)) ?
                        RankW'(sum_reg - (RankW+1)'(RankMod)) : RankW'(sum_reg);

    always_comb begin
        state_next    = state_reg;
        key_next      = key_reg;
        last_next     = last_reg;
        ovf_next      = ovf_reg;
        rank_next     = rank_reg;
        fact_next     = fact_reg;
        fact_new_next = fact_new_reg;
        pos_next      = pos_reg;
        pos_mod_next  = pos_mod_reg;
        sum_next      = sum_reg;
        m_data_next   = m_data_reg;
        shift_en      = 1'b0;
        cell_clear    = 1'b0;
        tree_in_valid = 1'b0;
        mul_req       = '{valid: 1'b0, tag: TagFact};
        mul_a         = '0;
        mul_b         = '0;
        m_valid_next  = m_valid_reg && !m_ready;

        // the factorial product is caught in any state; it can return while the count tree is still busy
        if (mul_rsp.valid && mul_rsp.tag == TagFact) begin
            fact_new_next = mul_rsp.result;
        end

        case (state_reg)
            StIdle: begin
                if (s_valid) begin
                    key_next   = key_in;
                    last_next  = s_data.last;
                    state_next = StCmp;
                end
            end
            StCmp: begin
                tree_in_valid = 1'b1;
                // factorial step needs only the old factorial and position
                mul_req       = '{valid: 1'b1, tag: TagFact};
                mul_a         = fact_reg;
                mul_b         = pos_mod_reg;
                state_next    = StCount;
            end
            StCount: begin
                if (cnt_res.valid) begin
                    shift_en   = !cnt_res.any_eq && !store_full;
                    ovf_next   = !cnt_res.any_eq && store_full;
                    mul_req    = '{valid: 1'b1, tag: TagRank};
                    mul_a      = RankW'(cnt);
                    mul_b      = fact_reg;
                    state_next = StMul;
                end
            end
            StMul: begin
                if (mul_rsp.valid && mul_rsp.tag == TagRank) begin
                    sum_next   = {1'b0, rank_reg} + {1'b0, mul_rsp.result};
                    state_next = StFin;
                end
            end
            StFin: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{rank: rank_final, done_res: last_reg, overflow: ovf_reg};
                    if (last_reg) begin
                        rank_next    = RankOne;
                        fact_next    = RankOne;
                        pos_next     = 32'd1;
                        pos_mod_next = RankOne;
                        cell_clear   = 1'b1;
                    end else begin
                        rank_next = rank_final;
                        fact_next = fact_new_reg;
                        pos_next  = pos_reg + 32'd1;
                        // residue goes to zero at RankMod, or when the position wraps at 2^32
                        if (pos_reg == 32'hFFFF_FFFF || pos_mod_reg == ModLast) begin
                            pos_mod_next = '0;
                        end else begin
                            pos_mod_next = pos_mod_reg + RankOne;
                        end
                    end
                    state_next = StIdle;
                end
            end
            default: begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= StIdle;
            rank_reg    <= RankOne;
            fact_reg    <= RankOne;
            pos_reg     <= 32'd1;
            pos_mod_reg <= RankOne;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rank_reg    <= rank_next;
            fact_reg    <= fact_next;
            pos_reg     <= pos_next;
            pos_mod_reg <= pos_mod_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        last_reg     <= last_next;
        ovf_reg      <= ovf_next;
        fact_new_reg <= fact_new_next;
        sum_reg      <= sum_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == StIdle);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: sv/prmp_checker.sv
// prmp_checker: port-level checks of the permutation rank unit, bound to the top level
// uses prmp_pkg and the port list of permutation_rank_mod_prime_unit

module prmp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input prmp_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input prmp_pkg::out_item_t m_data
);

    import prmp_pkg::*;

    // a stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // a waiting input transfer keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input changed or dropped while waiting");

    // the rank is always a reduced residue
    a_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.rank < RankMod))
        else $error("rank not reduced");

    // only one item in flight: ready drops after each input transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in flight");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

endmodule

bind permutation_rank_mod_prime_unit prmp_checker u_prmp_checker (.*);

// File: test/tb_top.sv
// tb_top: self-checking bench for permutation_rank_mod_prime_unit (rank modulo 1000000007)
// depends on prmp_pkg for the transfer structs and the modulus; predicts every result and
// compares it with what the m_ channel returns

class rank_scoreboard;
    prmp_pkg::out_item_t          expected_q[$];
    logic [31:0]                  seen_keys[$];
    logic [prmp_pkg::RankW-1:0]   rank_acc;
    logic [prmp_pkg::RankW-1:0]   fact_acc;
    logic [31:0]                  position;
    int unsigned                  store_depth;
    int                           failures;
    int                           n_inputs;
    int                           n_results;
    int                           n_sequences;
    int                           n_overflow;
    int                           n_duplicates;

    function new(int unsigned depth);
        store_depth = depth;
        failures = 0;
        n_inputs = 0;
        n_results = 0;
        n_sequences = 0;
        n_overflow = 0;
        n_duplicates = 0;
        clear_state();
    endfunction

    function void clear_state();
        seen_keys.delete();
        rank_acc = 1;
        fact_acc = 1;
        position = 1;
    endfunction

    // works out the running rank for one accepted element
    function void note_input(prmp_pkg::in_item_t item);
        logic [31:0]         key;
        int unsigned         below;
        bit                  present;
        longint unsigned     modulus;
        longint unsigned     term;
        prmp_pkg::out_item_t want;
        modulus = 64'(prmp_pkg::RankMod);
        // flipping the sign bit makes unsigned order match signed order
        key = 32'(item.value) ^ 32'h8000_0000;
        below = 0;
        present = 0;
        foreach (seen_keys[i]) begin
            if (seen_keys[i] < key)
                below++;
            else if (seen_keys[i] == key)
                present = 1;
        end
        term = (64'(below) * 64'(fact_acc)) % modulus;
        rank_acc = prmp_pkg::RankW'((64'(rank_acc) + term) % modulus);
        want.overflow = 1'b0;
        if (present) begin
            n_duplicates++;
        end else if (seen_keys.size() < store_depth) begin
            seen_keys = {seen_keys, key};
        end else begin
            want.overflow = 1'b1;
        end
        fact_acc = prmp_pkg::RankW'((64'(fact_acc) * 64'(position)) % modulus);
        position = position + 32'd1;
        want.rank = rank_acc;
        want.done_res = item.last;
        expected_q = {expected_q, want};
        n_inputs++;
        if (item.last)
            clear_state();
    endfunction

    function void check_result(prmp_pkg::out_item_t got);
        prmp_pkg::out_item_t want;
        n_results++;
        if (expected_q.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("[%0t] result with nothing expected: rank %0d done %0b ovf %0b",
                         $time, got.rank, got.done_res, got.overflow);
            return;
        end
        want = expected_q[0];
        expected_q.delete(0);
        if (want.done_res)
            n_sequences++;
        if (want.overflow)
            n_overflow++;
        if (got.rank !== want.rank || got.done_res !== want.done_res ||
            got.overflow !== want.overflow) begin
            failures++;
            if (failures <= 10)
                $display("[%0t] result %0d: rank %0d/%0d done %0b/%0b ovf %0b/%0b (exp/got)",
                         $time, n_results, want.rank, got.rank, want.done_res,
                         got.done_res, want.overflow, got.overflow);
        end
    endfunction
endclass

module tb_top;
    import prmp_pkg::*;

    localparam int unsigned MaxLen    = 256;
    localparam int unsigned ValueBits = 32;
    localparam int          ItemCount = 900;
    localparam int          DrainWait = 40;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    rank_scoreboard sb = new(MaxLen);

    logic [31:0] seq_values[$];
    bit          idle_on;
    bit          pressure_active;
    bit          pressure_done;
    int          items_sent;
    int          longest_seq;

    always #1 aclk = ~aclk;

    permutation_rank_mod_prime_unit #(
        .MAX_LEN    (MaxLen),
        .VALUE_BITS (ValueBits)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_element(input logic [31:0] value, input logic last);
        in_item_t item;
        int       gap;
        item.value = value;
        item.last = last;
        s_data <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(item);
        items_sent++;
        gap = (pressure_active || !idle_on) ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // sends seq_values in order, the final element flagged last
    task automatic send_sequence();
        int n;
        n = seq_values.size();
        if (n > longest_seq)
            longest_seq = n;
        for (int i = 0; i < n; i++)
            send_element(seq_values[i], i == n - 1);
        seq_values.delete();
    endtask

    function automatic logic [31:0] random_element(int mode);
        case (mode)
            0: return 32'($urandom_range(0, 8)) - 32'd4;
            1: return $urandom();
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
        endcase
    endfunction

    // MaxLen + 14 distinct values, shuffled, so that the store fills, then repeats and new ones
    task automatic send_filling_sequence();
        logic [31:0] base;
        logic [31:0] tmp;
        logic [31:0] elem;
        int          j;
        base = $urandom();
        for (int i = 0; i < MaxLen + 14; i++) begin
            elem = base + 32'(i) * 32'd5;
            seq_values = {seq_values, elem};
        end
        for (int i = seq_values.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = seq_values[i];
            seq_values[i] = seq_values[j];
            seq_values[j] = tmp;
        end
        for (int i = 0; i < 12; i++) begin
            elem = seq_values[$urandom_range(0, MaxLen + 13)];
            seq_values = {seq_values, elem};
        end
        for (int i = 0; i < 4; i++) begin
            elem = $urandom();
            seq_values = {seq_values, elem};
        end
        send_sequence();
    endtask

    task automatic send_random_sequence();
        int          len;
        int          mode;
        logic [31:0] elem;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        mode = $urandom_range(0, 2);
        for (int i = 0; i < len; i++) begin
            elem = random_element(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : mode);
            seq_values = {seq_values, elem};
        end
        send_sequence();
    endtask

    // result side: random stalls plus one long hold-off to back the block up
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_result(m_data);
            if (!pressure_done && sb.n_results >= 60) begin
                pressure_done = 1;
                pressure_active = 1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
                if (hold_left == 0)
                    pressure_active = 0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                hold_left = pick_gap();
                m_ready <= (hold_left == 0);
                if (hold_left > 0)
                    hold_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        idle_on = 1'b0;
        pressure_active = 0;
        pressure_done = 0;
        items_sent = 0;
        longest_seq = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // single element ending at once
        seq_values = '{32'h0000_0000};
        send_sequence();
        // signed extremes, zero and minus one
        seq_values = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        send_sequence();
        // repeated values are counted once
        seq_values = '{32'd5, 32'd5, 32'd3, 32'd5, 32'd3};
        send_sequence();
        idle_on = 1'b1;
        seq_values = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE, 32'h0000_0001,
                       32'h8000_0001};
        send_sequence();
        // rising run, each element above all stored ones
        seq_values = '{32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7};
        send_sequence();

        while (items_sent < ItemCount) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (items_sent > 200 && longest_seq <= MaxLen)
                send_filling_sequence();
            else
                send_random_sequence();
        end
        s_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);
        if (sb.expected_q.size() != 0) begin
            sb.failures++;
            $display("%0d results still outstanding", sb.expected_q.size());
        end

        $display("%0d elements in %0d sequences (longest %0d), %0d results checked",
                 sb.n_inputs, sb.n_sequences, longest_seq, sb.n_results);
        $display("repeated values %0d, store-full results %0d, failures %0d",
                 sb.n_duplicates, sb.n_overflow, sb.failures);
        if (sb.failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("timeout at %0t", $time);
        $display("TEST FAILED");
        $finish;
    end
endmodule

// File: files.f
sv/prmp_pkg.sv
sv/prmp_cell.sv
sv/prmp_count_tree.sv
sv/prmp_modmul.sv
sv/permutation_rank_mod_prime_unit.sv
sv/prmp_checker.sv
test/tb_top.sv
